### src/sals_pkg.sv
// Shared lamp masks, code tables and register indexes of the lamp sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sals_pkg;

	typedef logic [4:0] lamp_t;

	localparam lamp_t LAMP_RED   = 5'b00001;
	localparam lamp_t LAMP_GREEN = 5'b00010;
	localparam lamp_t LAMP_YTOP  = 5'b00100;
	localparam lamp_t LAMP_YBOT  = 5'b01000;
	localparam lamp_t LAMP_WHITE = 5'b10000;
	localparam lamp_t LAMP_NONE  = 5'b00000;
	localparam lamp_t LAMP_ALL   = 5'b11111;

	localparam int unsigned CODE_COUNT = 17;
	localparam logic [7:0] CODE_LIMIT = 8'(CODE_COUNT);

	localparam logic [1:0] REG_TABLE_SET    = 2'd0;
	localparam logic [1:0] REG_FLASH_PERIOD = 2'd1;
	localparam logic [1:0] REG_RED_HOLD     = 2'd2;

	localparam logic FUNC_SET  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam lamp_t STEADY_ROM [2][CODE_COUNT] = '{
		'{LAMP_RED, LAMP_GREEN, LAMP_YTOP, LAMP_NONE, LAMP_GREEN | LAMP_YBOT, LAMP_ALL,
		  LAMP_YTOP | LAMP_YBOT, LAMP_YBOT, LAMP_RED, LAMP_WHITE, LAMP_RED | LAMP_WHITE,
		  LAMP_GREEN | LAMP_WHITE, LAMP_YTOP | LAMP_WHITE, LAMP_NONE, LAMP_WHITE,
		  LAMP_YTOP | LAMP_WHITE | LAMP_YBOT, LAMP_WHITE | LAMP_YBOT},
		'{LAMP_WHITE | LAMP_YTOP, LAMP_WHITE | LAMP_GREEN, LAMP_WHITE | LAMP_GREEN,
		  LAMP_WHITE | LAMP_GREEN, LAMP_WHITE, LAMP_ALL, LAMP_WHITE, LAMP_WHITE,
		  LAMP_WHITE | LAMP_YTOP, LAMP_WHITE | LAMP_YTOP, LAMP_WHITE | LAMP_YTOP,
		  LAMP_WHITE | LAMP_GREEN, LAMP_WHITE | LAMP_YTOP, LAMP_NONE, LAMP_WHITE,
		  LAMP_WHITE | LAMP_YTOP, LAMP_WHITE}
	};

	localparam lamp_t FLASH_ROM [2][CODE_COUNT] = '{
		'{LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_YTOP, LAMP_NONE, LAMP_NONE, LAMP_NONE,
		  LAMP_YTOP, LAMP_WHITE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE,
		  LAMP_YTOP, LAMP_NONE, LAMP_YTOP},
		'{LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_YTOP, LAMP_NONE, LAMP_YTOP,
		  LAMP_YTOP, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE,
		  LAMP_YTOP, LAMP_NONE, LAMP_YTOP}
	};

	function automatic lamp_t lamp_steady(input logic set, input logic [4:0] code);
		logic [4:0] idx;
		idx = (code < 5'(CODE_COUNT)) ? code : 5'd0;
		return STEADY_ROM[set][idx];
	endfunction

	function automatic lamp_t lamp_flash(input logic set, input logic [4:0] code);
		logic [4:0] idx;
		idx = (code < 5'(CODE_COUNT)) ? code : 5'd0;
		return FLASH_ROM[set][idx];
	endfunction

endpackage
`default_nettype wire

### src/signal_aspect_lamp_sequencer.sv
// Top level of the signal aspect lamp sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Turns aspect codes and timer ticks into lamp fade-off and fade-on masks for five lamps
// (red bit 0, green 1, upper yellow 2, lower yellow 3, white 4). Each input transaction
// yields exactly one output transaction. One transaction per clock cycle is sustained
// while m_axis_tready is high; each item passes the input register and then the result
// register, and the lamp state is updated as an item leaves the input register. Configuration
// registers are written through the cfg channel, which is always ready.
module signal_aspect_lamp_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] aspect_code
	input  wire logic        s_axis_tuser,   // [0] func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [4:0] ramp_down_mask, [9:5] ramp_up_mask,
	                                         // [10] flash_lit, [15:11] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import sals_pkg::*;

	logic       table_set_q;
	logic [7:0] flash_period_q;
	logic [7:0] red_hold_ticks_q;

	logic [4:0] shown_code_q;
	logic       code_valid_q;
	logic       flash_phase_q;
	logic [7:0] tick_count_q;
	logic [7:0] red_hold_q;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] code_s1;

	logic       out_valid_q;
	lamp_t      down_q;
	lamp_t      up_q;
	logic       flash_lit_q;

	logic       advance;
	logic       step;

	lamp_t      new_st;
	lamp_t      new_fl;
	lamp_t      cur_st;
	lamp_t      cur_fl;
	lamp_t      down_d;
	lamp_t      up_d;
	logic [4:0] shown_code_d;
	logic       code_valid_d;
	logic       flash_phase_d;
	logic [7:0] tick_count_d;
	logic [7:0] red_hold_d;
	logic [7:0] tick_next;
	logic [7:0] red_next;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;
	assign cfg_ready     = 1'b1;

	assign new_st    = lamp_steady(table_set_q, code_s1[4:0]);
	assign new_fl    = lamp_flash(table_set_q, code_s1[4:0]);
	assign cur_st    = lamp_steady(table_set_q, shown_code_q);
	assign cur_fl    = lamp_flash(table_set_q, shown_code_q);
	assign tick_next = tick_count_q + 8'd1;
	assign red_next  = red_hold_q - 8'd1;

	always_comb begin
		down_d        = LAMP_NONE;
		up_d          = LAMP_NONE;
		shown_code_d  = shown_code_q;
		code_valid_d  = code_valid_q;
		flash_phase_d = flash_phase_q;
		tick_count_d  = tick_count_q;
		red_hold_d    = red_hold_q;
		unique case (func_s1)
			FUNC_SET: begin
				if (code_s1 < CODE_LIMIT && !(code_valid_q && code_s1[4:0] == shown_code_q)) begin
					up_d = new_st | new_fl;
					if (code_valid_q) begin
						up_d   = up_d & ~cur_st;
						down_d = (cur_st | cur_fl) & ~(new_st | new_fl);
						if (flash_phase_q) begin
							up_d = up_d & ~cur_fl;
						end else begin
							down_d = down_d & ~cur_fl;
						end
						if ((new_st & LAMP_RED) == LAMP_NONE && (cur_st & LAMP_RED) != LAMP_NONE) begin
							red_hold_d = red_hold_ticks_q;
							down_d     = down_d & ~LAMP_RED;
						end
					end
					shown_code_d  = code_s1[4:0];
					code_valid_d  = 1'b1;
					flash_phase_d = 1'b1;
					tick_count_d  = 8'd0;
				end
			end
			FUNC_TICK: begin
				tick_count_d = tick_next;
				if (red_hold_q != 8'd0) begin
					red_hold_d = red_next;
					if (red_next == 8'd0) begin
						down_d = down_d | LAMP_RED;
					end
				end
				if (tick_next >= flash_period_q && code_valid_q) begin
					tick_count_d = 8'd0;
					if (flash_phase_q) begin
						down_d = down_d | cur_fl;
					end else begin
						up_d = up_d | cur_fl;
					end
					flash_phase_d = !flash_phase_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_set_q      <= 1'b0;
			flash_period_q   <= 8'd50;
			red_hold_ticks_q <= 8'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TABLE_SET:    table_set_q      <= cfg_data[0];
				REG_FLASH_PERIOD: flash_period_q   <= cfg_data;
				REG_RED_HOLD:     red_hold_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			shown_code_q  <= 5'd0;
			code_valid_q  <= 1'b0;
			flash_phase_q <= 1'b0;
			tick_count_q  <= 8'd0;
			red_hold_q    <= 8'd0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (step) begin
				shown_code_q  <= shown_code_d;
				code_valid_q  <= code_valid_d;
				flash_phase_q <= flash_phase_d;
				tick_count_q  <= tick_count_d;
				red_hold_q    <= red_hold_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1 <= s_axis_tuser;
			code_s1 <= s_axis_tdata;
		end
		if (step) begin
			down_q      <= down_d;
			up_q        <= up_d;
			flash_lit_q <= flash_phase_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, flash_lit_q, up_q, down_q};

`ifndef SYNTHESIS
	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (down_q & up_q) == LAMP_NONE)
		else $error("fade-off and fade-on masks overlap");

	a_phase_needs_aspect: assert property (@(posedge clk) disable iff (!arst_n)
		!code_valid_q |-> !flash_phase_q)
		else $error("flash phase set with no aspect shown");

	a_hold_needs_aspect: assert property (@(posedge clk) disable iff (!arst_n)
		!code_valid_q |-> red_hold_q == 8'd0)
		else $error("red hold running with no aspect shown");

	a_state_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(shown_code_q) && $stable(code_valid_q) && $stable(tick_count_q))
		else $error("lamp state changed with no item processed");
`endif

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the lamp sequencer: predicts lamp masks per transaction and compares.
`timescale 1ns / 1ps
module testbench;
	import sals_pkg::*;

	typedef struct packed {
		lamp_t down;
		lamp_t up;
		logic  lit;
	} lamp_result_t;

	localparam lamp_t ASPECT_STEADY [2][17] = '{
		'{LAMP_RED, LAMP_GREEN, LAMP_YTOP, LAMP_NONE, LAMP_GREEN | LAMP_YBOT, LAMP_ALL,
		  LAMP_YTOP | LAMP_YBOT, LAMP_YBOT, LAMP_RED, LAMP_WHITE, LAMP_RED | LAMP_WHITE,
		  LAMP_GREEN | LAMP_WHITE, LAMP_YTOP | LAMP_WHITE, LAMP_NONE, LAMP_WHITE,
		  LAMP_YTOP | LAMP_YBOT | LAMP_WHITE, LAMP_YBOT | LAMP_WHITE},
		'{LAMP_YTOP | LAMP_WHITE, LAMP_GREEN | LAMP_WHITE, LAMP_GREEN | LAMP_WHITE,
		  LAMP_GREEN | LAMP_WHITE, LAMP_WHITE, LAMP_ALL, LAMP_WHITE, LAMP_WHITE,
		  LAMP_YTOP | LAMP_WHITE, LAMP_YTOP | LAMP_WHITE, LAMP_YTOP | LAMP_WHITE,
		  LAMP_GREEN | LAMP_WHITE, LAMP_YTOP | LAMP_WHITE, LAMP_NONE, LAMP_WHITE,
		  LAMP_YTOP | LAMP_WHITE, LAMP_WHITE}
	};

	localparam lamp_t ASPECT_FLASH [2][17] = '{
		'{LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_YTOP, LAMP_NONE, LAMP_NONE, LAMP_NONE,
		  LAMP_YTOP, LAMP_WHITE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE,
		  LAMP_YTOP, LAMP_NONE, LAMP_YTOP},
		'{LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_YTOP, LAMP_NONE, LAMP_YTOP,
		  LAMP_YTOP, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE, LAMP_NONE,
		  LAMP_YTOP, LAMP_NONE, LAMP_YTOP}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tuser = FUNC_SET;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_TABLE_SET;
	logic [7:0]  cfg_data = 8'd0;

	logic       cur_table = 1'b0;
	logic [7:0] flash_ticks_cfg = 8'd50;
	logic [7:0] red_hold_cfg = 8'd20;
	logic [4:0] shown = 5'd0;
	logic       shown_ok = 1'b0;
	logic       phase_lit = 1'b0;
	logic [7:0] tick_cnt = 8'd0;
	logic [7:0] red_left = 8'd0;

	lamp_result_t expected_masks [$];
	int mismatch_count = 0;

	bit rx_free = 1'b1;
	bit rx_ready_now = 1'b1;
	int rx_run = 0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;

	signal_aspect_lamp_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic lamp_result_t predict_lamps(input logic func, input logic [7:0] code);
		lamp_result_t res;
		lamp_t new_st, new_all, cur_st, cur_fl, cur_all, fl;
		res.down = LAMP_NONE;
		res.up = LAMP_NONE;
		if (func == FUNC_SET) begin
			if (code < CODE_LIMIT && !(shown_ok && code == {3'b000, shown})) begin
				new_st = ASPECT_STEADY[cur_table][code[4:0]];
				new_all = new_st | ASPECT_FLASH[cur_table][code[4:0]];
				res.up = new_all;
				if (shown_ok) begin
					cur_st = ASPECT_STEADY[cur_table][shown];
					cur_fl = ASPECT_FLASH[cur_table][shown];
					cur_all = cur_st | cur_fl;
					res.up = res.up & ~cur_st;
					res.down = cur_all & ~new_all;
					if (phase_lit) begin
						res.up = res.up & ~cur_fl;
					end else begin
						res.down = res.down & ~cur_fl;
					end
					if ((new_st & LAMP_RED) == LAMP_NONE && (cur_st & LAMP_RED) != LAMP_NONE) begin
						red_left = red_hold_cfg;
						res.down = res.down & ~LAMP_RED;
					end
				end
				shown = code[4:0];
				shown_ok = 1'b1;
				phase_lit = 1'b1;
				tick_cnt = 8'd0;
			end
		end else begin
			tick_cnt = tick_cnt + 8'd1;
			if (red_left != 8'd0) begin
				red_left = red_left - 8'd1;
				if (red_left == 8'd0) begin
					res.down = res.down | LAMP_RED;
				end
			end
			if (tick_cnt >= flash_ticks_cfg && shown_ok) begin
				fl = ASPECT_FLASH[cur_table][shown];
				tick_cnt = 8'd0;
				if (phase_lit) begin
					res.down = res.down | fl;
				end else begin
					res.up = res.up | fl;
				end
				phase_lit = ~phase_lit;
			end
		end
		res.lit = phase_lit;
		return res;
	endfunction

	// Call at a rising edge; returns at the edge that accepts the transaction, tvalid still high.
	task automatic send_item(input logic func, input logic [7:0] code);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= code;
		@(negedge clk);
		while (!s_axis_tready) begin
			@(negedge clk);
		end
		expected_masks.push_back(predict_lamps(func, code));
		@(posedge clk);
	endtask

	task automatic set_aspect(input logic [7:0] code);
		send_item(FUNC_SET, code);
	endtask

	task automatic tick(input int n);
		repeat (n) send_item(FUNC_TICK, 8'($urandom));
	endtask

	task automatic pause_sender(input int n);
		if (n != 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			s_axis_tuser <= 1'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_masks.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Leaves cfg_valid high; configure drops it after the last write.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready) begin
			@(negedge clk);
		end
		case (idx)
			REG_TABLE_SET:    cur_table = val[0];
			REG_FLASH_PERIOD: flash_ticks_cfg = val;
			REG_RED_HOLD:     red_hold_cfg = val;
			default:          ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic ts, input logic [7:0] period, input logic [7:0] hold);
		wait_drained();
		write_reg(REG_TABLE_SET, {7'd0, ts});
		write_reg(REG_FLASH_PERIOD, period);
		write_reg(REG_RED_HOLD, hold);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			tick(1);
		end else if (r < 90) begin
			set_aspect(8'($urandom_range(0, CODE_COUNT - 1)));
		end else begin
			set_aspect(8'($urandom_range(CODE_COUNT, 255)));
		end
	endtask

	task automatic test_reset_defaults();
		rx_free = 1'b1;
		tick(1);
		set_aspect(8'd255);
		set_aspect(8'd17);
		set_aspect(8'd0);
		set_aspect(8'd0);
		set_aspect(8'd8);
		set_aspect(8'd1);
		set_aspect(8'd16);
	endtask

	task automatic test_flash_and_red_hold();
		configure(1'b0, 8'd1, 8'd2);
		set_aspect(8'd3);
		tick(2);
		set_aspect(8'd0);
		set_aspect(8'd1);
		tick(1);
		set_aspect(8'd0);
		set_aspect(8'd1);
		tick(1);
		set_aspect(8'd0);
		tick(1);
	endtask

	task automatic test_zero_registers();
		configure(1'b1, 8'd0, 8'd0);
		set_aspect(8'd4);
		tick(2);
		set_aspect(8'd5);
		set_aspect(8'd6);
		tick(1);
	endtask

	task automatic test_backpressure();
		configure(1'b0, 8'd3, 8'd4);
		rx_free = 1'b0;
		rx_hold_req = 150;
		repeat (40) send_random_item();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int sent;
		int burst;
		bit tx_steady;
		logic       ts;
		logic [7:0] period, hold;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin ts = 1'b0; period = 8'd1; hold = 8'd1; end
				1: begin ts = 1'b1; period = 8'd255; hold = 8'd255; end
				2: begin ts = 1'b0; period = 8'd0; hold = 8'd0; end
				3: begin ts = 1'b1; period = 8'd2; hold = 8'd3; end
				default: begin
					ts = 1'($urandom);
					period = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					                                     : 8'($urandom_range(1, 6));
					hold = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					                                   : 8'($urandom_range(1, 8));
				end
			endcase
			configure(ts, period, hold);
			tx_steady = (p == 3 || p == 6);
			rx_free = tx_steady;
			sent = 0;
			while (sent < 185) begin
				burst = $urandom_range(1, 16);
				repeat (burst) send_random_item();
				sent += burst;
				if (!tx_steady) begin
					pause_sender($urandom_range(0, 6));
				end
			end
		end
	endtask

	initial begin : rx_stall
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				rx_hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_free) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (rx_run == 0) begin
					rx_ready_now = ~rx_ready_now;
					rx_run = rx_ready_now ? $urandom_range(1, 12) : $urandom_range(1, 5);
				end
				rx_run--;
				m_axis_tready <= rx_ready_now;
			end
		end
	end

	initial begin : result_check
		lamp_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_masks.size() == 0) begin
					$error("unexpected transaction: tdata %h", m_axis_tdata);
					mismatch_count++;
				end else begin
					want = expected_masks.pop_front();
					if (m_axis_tdata[4:0] !== want.down) begin
						$error("ramp_down_mask: expected %h, got %h", want.down, m_axis_tdata[4:0]);
						mismatch_count++;
					end
					if (m_axis_tdata[9:5] !== want.up) begin
						$error("ramp_up_mask: expected %h, got %h", want.up, m_axis_tdata[9:5]);
						mismatch_count++;
					end
					if (m_axis_tdata[10] !== want.lit) begin
						$error("flash_lit: expected %b, got %b", want.lit, m_axis_tdata[10]);
						mismatch_count++;
					end
					if (m_axis_tdata[15:11] !== 5'd0) begin
						$error("pad: expected %h, got %h", 5'd0, m_axis_tdata[15:11]);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_flash_and_red_hold();
		test_zero_registers();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
